// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file for its concurrent checks.
// Expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hvd_pkg.sv
// Package for the HMM Viterbi path decoder: field widths, config codes,
// cost table, command and back-end state types. No dependencies.
package hvd_pkg;

  localparam int STATE_W     = 2;
  localparam int SYM_W       = 2;
  localparam int STEP_W      = 6;
  localparam int METRIC_W    = 16;
  localparam int COST_W      = 8;
  localparam int MAX_STATES  = 4;
  localparam int MAX_SYMBOLS = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [METRIC_W-1:0] METRIC_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_COSTS = 3'd0,
    CFG_TRANS_LOW   = 3'd1,
    CFG_TRANS_HIGH  = 3'd2,
    CFG_EMIT_LOW    = 3'd3,
    CFG_EMIT_HIGH   = 3'd4
  } cfg_reg_t;

  // Byte layout matches the register layout: trans[from][to], emit[state][symbol].
  typedef struct packed {
    logic [MAX_STATES-1:0][MAX_SYMBOLS-1:0][COST_W-1:0] emit;
    logic [MAX_STATES-1:0][MAX_STATES-1:0][COST_W-1:0]  trans;
    logic [MAX_STATES-1:0][COST_W-1:0]                  start;
  } cost_tbl_t;

  typedef enum logic [1:0] {
    OP_FIRST,
    OP_STEP,
    OP_TRACE
  } cmd_op_t;

  // t: step index of this item; for a final item it is also the last path index.
  typedef struct packed {
    cmd_op_t            op;
    logic [SYM_W-1:0]   sym;
    logic               fin;
    logic               ovf;
    logic [STEP_W-1:0]  t;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_TB_START,
    B_TB_RUN,
    B_EM_RD,
    B_EM_LD
  } back_state_t;

endpackage

// File: rtl/hvd_if.sv
// Valid/ready channel interfaces for the decoder's observation input and
// path result output. Depends on hvd_pkg.
interface hvd_in_if;
  import hvd_pkg::*;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             first;
  logic             final_item;

  modport source (output valid, symbol, first, final_item, input ready);
  modport sink   (input valid, symbol, first, final_item, output ready);
endinterface

interface hvd_out_if;
  import hvd_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATE_W-1:0]  path_state;
  logic [STEP_W-1:0]   step_index;
  logic                last_of_run;
  logic [METRIC_W-1:0] best_cost;
  logic                overflow;

  modport source (output valid, path_state, step_index, last_of_run, best_cost, overflow,
                  input ready);
  modport sink   (input valid, path_state, step_index, last_of_run, best_cost, overflow,
                  output ready);
endinterface

// File: rtl/hvd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hvd_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/hvd_front.sv
// Front end: accepts observations, tracks sequence state and step count,
// turns each item it keeps into a back-end command. Depends on hvd_pkg, hvd_if.
module hvd_front #(
  parameter int NUM_SYMBOLS = 4,
  parameter int MAX_LEN     = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  hvd_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          q_push,
  output hvd_pkg::cmd_t q_wdata
);
  import hvd_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic             open_r, open_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             accept;
  logic             push_cmd;
  logic [SYM_W-1:0] sym_cl;
  cmd_t             cmd;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // out-of-range symbols clamp to the last one
  assign sym_cl = ({1'b0, in_ch.symbol} >= (SYM_W + 1)'(NUM_SYMBOLS)) ?
                  SYM_W'(NUM_SYMBOLS - 1) : in_ch.symbol;

  always_comb begin
    cmd.op    = OP_STEP;
    cmd.sym   = sym_cl;
    cmd.fin   = in_ch.final_item;
    cmd.ovf   = ovf_r;
    cmd.t     = STEP_W'(count_r);
    push_cmd  = 1'b0;
    open_nxt  = open_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    priority if (in_ch.first) begin
      cmd.op    = OP_FIRST;
      cmd.t     = '0;
      cmd.ovf   = 1'b0;
      push_cmd  = 1'b1;
      open_nxt  = !in_ch.final_item;
      count_nxt = in_ch.final_item ? '0 : CNT_W'(1);
      ovf_nxt   = 1'b0;
    end else if (open_r && (count_r >= CNT_W'(MAX_LEN))) begin
      // full: drop the item, but a final one still triggers the traceback
      ovf_nxt  = 1'b1;
      cmd.op   = OP_TRACE;
      cmd.ovf  = 1'b1;
      cmd.t    = STEP_W'(MAX_LEN - 1);
      push_cmd = in_ch.final_item;
      if (in_ch.final_item) begin
        open_nxt  = 1'b0;
        count_nxt = '0;
      end
    end else if (open_r) begin
      push_cmd  = 1'b1;
      open_nxt  = !in_ch.final_item;
      count_nxt = in_ch.final_item ? '0 : count_r + 1'b1;
    end else begin
      // no open sequence: the item is taken and dropped
      push_cmd = 1'b0;
    end
  end

  assign q_push  = accept && push_cmd;
  assign q_wdata = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      open_r  <= open_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// File: rtl/hvd_queue.sv
// Short command FIFO between front and back end.
// Depends on hvd_pkg.
module hvd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hvd_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output hvd_pkg::cmd_t pop_data,
  output logic          empty
);
  import hvd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/hvd_back.sv
// Back end: add-compare-select, backpointer store, traceback and in-order
// path emission. Depends on hvd_pkg, hvd_if, hvd_ram.
module hvd_back #(
  parameter int NUM_STATES = 4,
  parameter int MAX_LEN    = 64,
  parameter int COST_BITS  = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hvd_pkg::cost_tbl_t tbl,
  input  logic               q_empty,
  input  hvd_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  hvd_out_if.source          out_ch
);
  import hvd_pkg::*;

  localparam int AW     = $clog2(MAX_LEN);
  localparam int SIDX_W = $clog2(NUM_STATES);
  localparam int SUM_W  = METRIC_W + 2;

  back_state_t state_r, state_nxt;

  logic [NUM_STATES-1:0][METRIC_W-1:0] pm_r, pm_nxt, acs_pm, init_pm;
  logic [NUM_STATES-1:0][STATE_W-1:0]  acs_bp, bp_row;
  logic [AW-1:0]       n_m1_r, n_m1_nxt, tb_t_r, tb_t_nxt, em_t_r, em_t_nxt;
  logic [STATE_W-1:0]  cur_r, cur_nxt, best_st, bp_prev;
  logic [METRIC_W-1:0] cost_r, cost_nxt, best_cost;
  logic                ovf_r, ovf_nxt;
  logic                out_free, em_last;

  logic                out_valid_r, out_valid_nxt;
  logic [STATE_W-1:0]  out_state_r, out_state_nxt;
  logic [STEP_W-1:0]   out_step_r, out_step_nxt;
  logic                out_last_r, out_last_nxt;
  logic [METRIC_W-1:0] out_cost_r, out_cost_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic                           bp_we, bp_re;
  logic [AW-1:0]                  bp_waddr, bp_raddr;
  logic [NUM_STATES*STATE_W-1:0]  bp_rdata;
  logic                           pt_we, pt_re;
  logic [AW-1:0]                  pt_waddr, pt_raddr;
  logic [STATE_W-1:0]             pt_wdata, pt_rdata;

  hvd_ram #(.WIDTH(NUM_STATES * STATE_W), .DEPTH(MAX_LEN)) u_bp_ram (
    .clk   (clk),
    .we    (bp_we),
    .waddr (bp_waddr),
    .wdata (acs_bp),
    .re    (bp_re),
    .raddr (bp_raddr),
    .rdata (bp_rdata)
  );

  hvd_ram #(.WIDTH(STATE_W), .DEPTH(MAX_LEN)) u_path_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .re    (pt_re),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  assign bp_row  = bp_rdata;
  assign bp_prev = bp_row[cur_r[SIDX_W-1:0]];

  // Initial metrics and one ACS step; sums saturate at METRIC_MAX.
  always_comb begin : acs
    logic [SUM_W-1:0]    sum;
    logic [METRIC_W-1:0] cand, bm;
    logic [STATE_W-1:0]  bi;
    acs_pm  = pm_r;
    init_pm = pm_r;
    acs_bp  = '0;
    sum     = '0;
    cand    = '0;
    bm      = '0;
    bi      = '0;
    for (int s = 0; s < NUM_STATES; s++) begin
      sum = SUM_W'(tbl.start[s][COST_BITS-1:0]) + SUM_W'(tbl.emit[s][q_cmd.sym][COST_BITS-1:0]);
      init_pm[s] = (sum > SUM_W'(METRIC_MAX)) ? METRIC_MAX : sum[METRIC_W-1:0];
      bm = METRIC_MAX;
      bi = '0;
      for (int i = 0; i < NUM_STATES; i++) begin
        sum = SUM_W'(pm_r[i]) + SUM_W'(tbl.trans[i][s][COST_BITS-1:0])
            + SUM_W'(tbl.emit[s][q_cmd.sym][COST_BITS-1:0]);
        cand = (sum > SUM_W'(METRIC_MAX)) ? METRIC_MAX : sum[METRIC_W-1:0];
        // strict compare keeps the lowest index on ties
        if ((i == 0) || (cand < bm)) begin
          bm = cand;
          bi = STATE_W'(i);
        end
      end
      acs_pm[s] = bm;
      acs_bp[s] = bi;
    end
  end

  always_comb begin : best_pick
    best_st   = '0;
    best_cost = pm_r[0];
    for (int s = 1; s < NUM_STATES; s++) begin
      if (pm_r[s] < best_cost) begin
        best_cost = pm_r[s];
        best_st   = STATE_W'(s);
      end
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign em_last  = (em_t_r == n_m1_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty && q_cmd.fin) begin
          state_nxt = B_TB_START;
        end
      end
      B_TB_START: state_nxt = (n_m1_r == '0) ? B_EM_RD : B_TB_RUN;
      B_TB_RUN: begin
        if (tb_t_r == AW'(1)) begin
          state_nxt = B_EM_RD;
        end
      end
      B_EM_RD: begin
        if (out_free) begin
          state_nxt = B_EM_LD;
        end
      end
      B_EM_LD: state_nxt = em_last ? B_IDLE : B_EM_RD;
      default: state_nxt = B_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    q_pop    = 1'b0;
    bp_we    = 1'b0;
    bp_waddr = q_cmd.t[AW-1:0];
    bp_re    = 1'b0;
    bp_raddr = n_m1_r;
    pt_we    = 1'b0;
    pt_waddr = n_m1_r;
    pt_wdata = best_st;
    pt_re    = 1'b0;
    pt_raddr = em_t_r;
    pm_nxt   = pm_r;
    n_m1_nxt = n_m1_r;
    tb_t_nxt = tb_t_r;
    cur_nxt  = cur_r;
    em_t_nxt = em_t_r;
    cost_nxt = cost_r;
    ovf_nxt  = ovf_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_state_nxt = out_state_r;
    out_step_nxt  = out_step_r;
    out_last_nxt  = out_last_r;
    out_cost_nxt  = out_cost_r;
    out_ovf_nxt   = out_ovf_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          n_m1_nxt = q_cmd.t[AW-1:0];
          ovf_nxt  = q_cmd.ovf;
          unique case (q_cmd.op)
            OP_FIRST: pm_nxt = init_pm;
            OP_STEP: begin
              pm_nxt = acs_pm;
              bp_we  = 1'b1;
            end
            default: pm_nxt = pm_r;
          endcase
        end
      end
      B_TB_START: begin
        cost_nxt = best_cost;
        cur_nxt  = best_st;
        pt_we    = 1'b1;
        bp_re    = 1'b1;
        tb_t_nxt = n_m1_r;
        em_t_nxt = '0;
      end
      B_TB_RUN: begin
        // row tb_t_r is on the read port; step one entry back
        pt_we    = 1'b1;
        pt_waddr = tb_t_r - 1'b1;
        pt_wdata = bp_prev;
        cur_nxt  = bp_prev;
        bp_re    = 1'b1;
        bp_raddr = tb_t_r - 1'b1;
        tb_t_nxt = tb_t_r - 1'b1;
      end
      B_EM_RD: begin
        pt_re = out_free;
      end
      B_EM_LD: begin
        out_valid_nxt = 1'b1;
        out_state_nxt = pt_rdata;
        out_step_nxt  = STEP_W'(em_t_r);
        out_last_nxt  = em_last;
        out_cost_nxt  = cost_r;
        out_ovf_nxt   = ovf_r;
        em_t_nxt      = em_t_r + 1'b1;
      end
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      pm_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pm_r        <= pm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_m1_r      <= n_m1_nxt;
    tb_t_r      <= tb_t_nxt;
    cur_r       <= cur_nxt;
    em_t_r      <= em_t_nxt;
    cost_r      <= cost_nxt;
    ovf_r       <= ovf_nxt;
    out_state_r <= out_state_nxt;
    out_step_r  <= out_step_nxt;
    out_last_r  <= out_last_nxt;
    out_cost_r  <= out_cost_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.path_state  = out_state_r;
  assign out_ch.step_index  = out_step_r;
  assign out_ch.last_of_run = out_last_r;
  assign out_ch.best_cost   = out_cost_r;
  assign out_ch.overflow    = out_ovf_r;

endmodule

// File: rtl/hmm_viterbi_path_decoder_unit.sv
// Top level of the HMM Viterbi path decoder: config registers, front end,
// command queue and back end. Depends on hvd_pkg, hvd_if, hvd_front,
// hvd_queue, hvd_back, assert_macros.svh.
//
// Decodes the most likely hidden-state path of a hidden Markov model with up
// to four states and four symbols, working in 8-bit negative-log costs so that
// sums replace products and the minimum replaces the maximum (ties go to the
// lower state index; metrics saturate at 16 bits). One observation is one
// transfer on in_ch. An item with first=1 opens a sequence; later items run
// add-compare-select and store one backpointer row per step; an item with
// final_item=1 starts the traceback, after which the path is sent on out_ch,
// one transfer per time step in ascending order, each carrying the best cost
// and the overflow flag. Items arriving while no sequence is open are taken
// and dropped; items beyond MAX_LEN steps are dropped and flagged in overflow.
// Timing: the front end takes one item per cycle, while the queue is not full,
// into a two-entry command queue; the back end retires a non-final item with
// one ACS pass over all states. For a final item of an n-step sequence the
// back end updates the metrics as for any item, picks the best state, walks
// n-1 traceback steps (one backpointer RAM read each), then for each result
// reads the path RAM and loads the output register, waiting while out_ch is
// stalled. The result register frees the back end once the last entry is
// loaded. Config writes must only happen while idle.
`include "assert_macros.svh"

module hmm_viterbi_path_decoder_unit #(
  parameter int NUM_STATES  = 4,
  parameter int NUM_SYMBOLS = 4,
  parameter int MAX_LEN     = 64,
  parameter int COST_BITS   = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  hvd_in_if.sink                         in_ch,
  hvd_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [hvd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [hvd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hvd_pkg::*;

  cost_tbl_t tbl_r;
  logic      q_push, q_full, q_pop, q_empty;
  cmd_t      q_wdata, q_cmd;
  logic      pop_trace, pop_first;

  // Config registers: costs are stored as written; the back end masks them
  // to COST_BITS. Unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        CFG_START_COSTS: tbl_r.start       <= cfg_wdata[31:0];
        CFG_TRANS_LOW:   tbl_r.trans[1:0]  <= cfg_wdata;
        CFG_TRANS_HIGH:  tbl_r.trans[3:2]  <= cfg_wdata;
        CFG_EMIT_LOW:    tbl_r.emit[1:0]   <= cfg_wdata;
        CFG_EMIT_HIGH:   tbl_r.emit[3:2]   <= cfg_wdata;
        default:         tbl_r             <= tbl_r;
      endcase
    end
  end

  // Front end: sequence tracking and item classification.
  hvd_front #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .MAX_LEN     (MAX_LEN)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  // Decouples input acceptance from traceback and emission bursts.
  hvd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_cmd),
    .empty     (q_empty)
  );

  // Back end: ACS, traceback, result register.
  hvd_back #(
    .NUM_STATES (NUM_STATES),
    .MAX_LEN    (MAX_LEN),
    .COST_BITS  (COST_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .tbl     (tbl_r),
    .q_empty (q_empty),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  assign pop_trace = q_pop && (q_cmd.op == OP_TRACE);
  assign pop_first = q_pop && (q_cmd.op == OP_FIRST);

  // Queue is never popped empty nor pushed full.
  `ASSERT_IMPL(a_pop_nonempty, q_pop, !q_empty, "command popped from empty queue")
  `ASSERT_IMPL(a_push_room, q_push, !q_full, "command pushed into full queue")
  // A trace-only command only comes from a dropped final item.
  `ASSERT_IMPL(a_trace_final, pop_trace, q_cmd.fin && q_cmd.ovf, "orphan trace command")
  // A sequence start always sits at step zero with a clean overflow flag.
  `ASSERT_IMPL(a_first_clean, pop_first, (q_cmd.t == '0) && !q_cmd.ovf, "unclean first command")

endmodule
